@@ rtl/core/sscd_pkg.sv @@
// Shared constants and types for the sweep scan change detector.
`default_nettype none
package sscd_pkg;
  localparam int ANGLE_COUNT  = 64;
  localparam int ANGLE_W      = $clog2(ANGLE_COUNT);
  localparam int SAMPLE_W     = 31;
  localparam int STEPS_W      = 6;
  localparam int MAX_STEPS    = 32;
  localparam int STEP_IDX_W   = $clog2(MAX_STEPS);
  localparam int SCAN_ANGLE_W = 6;
  localparam int COIL_W       = 4;
  localparam int PHASE_W      = 2;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 31;

  localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET = SAMPLE_W'(50);
  localparam logic [STEPS_W-1:0]  STEPS_RESET     = STEPS_W'(MAX_STEPS);
  localparam logic [PHASE_W-1:0]  PHASE_RESET     = 2'd3;
  localparam logic [ANGLE_W-1:0]  ANGLE_TOP       = ANGLE_W'(ANGLE_COUNT - 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD = 1'b0,
    CFG_STEPS     = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic issue;
    logic last;
  } step_ctl_t;

  typedef struct packed {
    logic [COIL_W-1:0]       coil_pattern;
    logic                    last_step;
    logic [SCAN_ANGLE_W-1:0] scan_angle;
    logic                    changed;
    logic [SAMPLE_W-1:0]     reported_value;
  } result_t;
endpackage
`default_nettype wire

@@ rtl/core/sscd_if.sv @@
// Valid/ready channel interfaces for sample and result words.
`default_nettype none
interface sscd_in_if;
  import sscd_pkg::*;
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] distance;
  modport source(output valid, output distance, input ready);
  modport sink(input valid, input distance, output ready);
endinterface

interface sscd_out_if;
  import sscd_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [COIL_W-1:0]       coil_pattern;
  logic                    last_step;
  logic [SCAN_ANGLE_W-1:0] scan_angle;
  logic                    changed;
  logic [SAMPLE_W-1:0]     reported_value;
  modport source(output valid, output coil_pattern, output last_step, output scan_angle,
                 output changed, output reported_value, input ready);
  modport sink(input valid, input coil_pattern, input last_step, input scan_angle,
               input changed, input reported_value, output ready);
endinterface
`default_nettype wire

@@ rtl/core/sweep_scan_change_detector_unit.sv @@
// Top level of the sweep scan change detector.
// A taken sample word is held in the input word register; each result word is registered.
// Throughput: one result word (one step) per cycle unless results.ready stalls, set by the
// single output register; a sample yields steps_per_angle step words (1 to 32).
// Reset: synchronous; the value table reads as zero right after reset (valid bits).
`default_nettype none
module sweep_scan_change_detector_unit (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [sscd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [sscd_pkg::CFG_DATA_W-1:0] cfg_data,
  sscd_in_if.sink                              samples,
  sscd_out_if.source                           results
);
  import sscd_pkg::*;

  logic [SAMPLE_W-1:0] change_threshold;
  logic [STEPS_W-1:0]  steps_per_angle;
  step_ctl_t           ctl;
  logic [SAMPLE_W-1:0] sample;
  logic                changed;
  logic [SAMPLE_W-1:0] old_value;
  logic [ANGLE_W-1:0]  pos;
  logic [ANGLE_W-1:0]  pos_next;
  logic [COIL_W-1:0]   coil_pattern;
  logic                out_free;
  logic                wr_en;
  logic                res_valid;
  result_t             res;

  always_ff @(posedge clk) begin
    if (rst) begin
      change_threshold <= THRESHOLD_RESET;
      steps_per_angle  <= STEPS_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_THRESHOLD: change_threshold <= cfg_data[SAMPLE_W-1:0];
        CFG_STEPS:     steps_per_angle  <= cfg_data[STEPS_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_free = !res_valid || results.ready;
  assign wr_en    = ctl.issue && ctl.last && changed;

  sscd_sequencer u_seq (
    .clk,
    .rst,
    .samples,
    .steps_per_angle,
    .change_threshold,
    .old_value,
    .out_free,
    .ctl,
    .sample,
    .changed
  );

  sscd_sweep u_sweep (
    .clk,
    .rst,
    .ctl,
    .pos,
    .pos_next,
    .coil_pattern
  );

  sscd_table u_table (
    .clk,
    .rst,
    .wr_en,
    .wr_addr  (pos),
    .wr_data  (sample),
    .rd_addr  (pos_next),
    .rd_value (old_value)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_free) begin
      res_valid <= ctl.issue;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.issue) begin
      res.coil_pattern   <= coil_pattern;
      res.last_step      <= ctl.last;
      res.scan_angle     <= SCAN_ANGLE_W'(pos);
      res.changed        <= wr_en;
      res.reported_value <= wr_en ? sample : old_value;
    end
  end

  assign results.valid          = res_valid;
  assign results.coil_pattern   = res.coil_pattern;
  assign results.last_step      = res.last_step;
  assign results.scan_angle     = res.scan_angle;
  assign results.changed        = res.changed;
  assign results.reported_value = res.reported_value;
endmodule
`default_nettype wire

@@ rtl/core/sscd_table.sv @@
// Last-reported value table with registered read, write bypass and valid bits.
`default_nettype none
module sscd_table (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           wr_en,
  input  wire logic [sscd_pkg::ANGLE_W-1:0]   wr_addr,
  input  wire logic [sscd_pkg::SAMPLE_W-1:0]  wr_data,
  input  wire logic [sscd_pkg::ANGLE_W-1:0]   rd_addr,
  output logic      [sscd_pkg::SAMPLE_W-1:0]  rd_value
);
  import sscd_pkg::*;

  logic [SAMPLE_W-1:0]    mem [ANGLE_COUNT];
  logic [ANGLE_COUNT-1:0] vld;
  logic [SAMPLE_W-1:0]    rd_data;
  logic                   rd_vld;
  logic                   byp;
  logic [SAMPLE_W-1:0]    byp_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data  <= mem[rd_addr];
    byp_data <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
      byp    <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      rd_vld <= vld[rd_addr];
      byp    <= wr_en && (wr_addr == rd_addr);
    end
  end

  assign rd_value = byp ? byp_data : (rd_vld ? rd_data : '0);
endmodule
`default_nettype wire

@@ rtl/core/sscd_sequencer.sv @@
// Input word register, step counter and change compare.
`default_nettype none
module sscd_sequencer (
  input  wire logic                          clk,
  input  wire logic                          rst,
  sscd_in_if.sink                            samples,
  input  wire logic [sscd_pkg::STEPS_W-1:0]  steps_per_angle,
  input  wire logic [sscd_pkg::SAMPLE_W-1:0] change_threshold,
  input  wire logic [sscd_pkg::SAMPLE_W-1:0] old_value,
  input  wire logic                          out_free,
  output sscd_pkg::step_ctl_t                ctl,
  output logic      [sscd_pkg::SAMPLE_W-1:0] sample,
  output logic                               changed
);
  import sscd_pkg::*;

  logic                  held;
  logic [STEP_IDX_W-1:0] k;
  logic [STEP_IDX_W-1:0] last_idx;
  logic [SAMPLE_W-1:0]   diff;
  logic                  take;

  always_comb begin
    if (steps_per_angle == '0) begin
      last_idx = '0;
    end else if (steps_per_angle > STEPS_W'(MAX_STEPS)) begin
      last_idx = STEP_IDX_W'(MAX_STEPS - 1);
    end else begin
      last_idx = STEP_IDX_W'(steps_per_angle - STEPS_W'(1));
    end
  end

  assign ctl.issue     = held && out_free;
  assign ctl.last      = (k == last_idx);
  assign samples.ready = !held || (ctl.issue && ctl.last);
  assign take          = samples.valid && samples.ready;

  assign diff    = (sample >= old_value) ? (sample - old_value) : (old_value - sample);
  assign changed = diff >= change_threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
      k    <= '0;
    end else begin
      if (ctl.issue) begin
        k <= ctl.last ? '0 : k + STEP_IDX_W'(1);
      end
      if (take) begin
        held <= 1'b1;
      end else if (ctl.issue && ctl.last) begin
        held <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      sample <= samples.distance;
    end
  end
endmodule
`default_nettype wire

@@ rtl/core/sscd_sweep.sv @@
// Sweep angle, direction and coil phase state.
`default_nettype none
module sscd_sweep (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire sscd_pkg::step_ctl_t          ctl,
  output logic      [sscd_pkg::ANGLE_W-1:0] pos,
  output logic      [sscd_pkg::ANGLE_W-1:0] pos_next,
  output logic      [sscd_pkg::COIL_W-1:0]  coil_pattern
);
  import sscd_pkg::*;

  logic               down;
  logic               down_next;
  logic [PHASE_W-1:0] phase;
  logic [PHASE_W-1:0] phase_next;

  assign phase_next   = down ? phase - PHASE_W'(1) : phase + PHASE_W'(1);
  assign coil_pattern = COIL_W'(1) << phase_next;

  always_comb begin
    pos_next  = pos;
    down_next = down;
    if (ctl.issue && ctl.last) begin
      if (down) begin
        if (pos == '0) begin
          down_next = 1'b0;
        end else begin
          pos_next = pos - ANGLE_W'(1);
        end
      end else begin
        if (pos == ANGLE_TOP) begin
          down_next = 1'b1;
        end else begin
          pos_next = pos + ANGLE_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos   <= ANGLE_TOP;
      down  <= 1'b1;
      phase <= PHASE_RESET;
    end else begin
      pos  <= pos_next;
      down <= down_next;
      if (ctl.issue) begin
        phase <= phase_next;
      end
    end
  end
endmodule
`default_nettype wire

@@ test/tb.sv @@
// Self-checking bench for the sweep scan change detector: step words vs. a sweep predictor.
`timescale 1ns / 1ps
module tb;
  import sscd_pkg::*;

  localparam int LIMIT_CYCLES = 1000000;
  localparam logic [SAMPLE_W-1:0] DIST_MAX = {SAMPLE_W{1'b1}};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  sscd_in_if  samples_if ();
  sscd_out_if results_if ();

  sweep_scan_change_detector_unit dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .samples(samples_if),
    .results(results_if)
  );

  always #1 clk = ~clk;

  // sweep predictor state
  logic [SAMPLE_W-1:0] thresh_cfg;
  logic [STEPS_W-1:0]  step_cfg;
  logic [ANGLE_W-1:0]  sweep_pos;
  logic                sweep_dn;
  logic [PHASE_W-1:0]  coil_ph;
  logic [SAMPLE_W-1:0] stored_val [ANGLE_COUNT];

  logic [SAMPLE_W-1:0] pending_distances [$];
  result_t             expected_steps [$];

  int  fail_count = 0;
  int  samples_taken = 0;
  int  words_checked = 0;
  int  changes_seen = 0;
  int  settings_used = 0;
  int  cycle_count = 0;
  logic tx_gaps_on = 1'b1;
  logic rx_stall_on = 1'b1;
  logic in_fire = 1'b0;

  function void predict_sample(input logic [SAMPLE_W-1:0] sample);
    logic [SAMPLE_W-1:0] old_val;
    logic [SAMPLE_W-1:0] diff;
    int                  steps;
    int                  k;
    logic                hit;
    result_t             r;
    old_val = stored_val[sweep_pos];
    if (step_cfg == 0) steps = 1;
    else if (step_cfg > MAX_STEPS) steps = MAX_STEPS;
    else steps = step_cfg;
    diff = (sample >= old_val) ? sample - old_val : old_val - sample;
    hit = (diff >= thresh_cfg);
    for (k = 0; k < steps; k++) begin
      coil_ph = sweep_dn ? coil_ph - 1'b1 : coil_ph + 1'b1;
      r.coil_pattern = COIL_W'(1) << coil_ph;
      r.last_step = (k == steps - 1);
      r.scan_angle = SCAN_ANGLE_W'(sweep_pos);
      if (r.last_step && hit) begin
        stored_val[sweep_pos] = sample;
        r.changed = 1'b1;
        r.reported_value = sample;
      end else begin
        r.changed = 1'b0;
        r.reported_value = stored_val[sweep_pos];
      end
      expected_steps.push_back(r);
    end
    if (sweep_dn) begin
      if (sweep_pos == 0) sweep_dn = 1'b0;
      else sweep_pos = sweep_pos - 1'b1;
    end else begin
      if (sweep_pos == ANGLE_TOP) sweep_dn = 1'b1;
      else sweep_pos = sweep_pos + 1'b1;
    end
  endfunction

  function logic [SAMPLE_W-1:0] pick_distance();
    logic [SAMPLE_W-1:0] d;
    case ($urandom_range(0, 5))
      0: d = SAMPLE_W'($urandom_range(0, 120));
      1: d = DIST_MAX - SAMPLE_W'($urandom_range(0, 120));
      2: d = '0;
      3: d = DIST_MAX;
      default: d = SAMPLE_W'($urandom);
    endcase
    return d;
  endfunction

  task automatic write_register(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_THRESHOLD) thresh_cfg = val[SAMPLE_W-1:0];
    else step_cfg = val[STEPS_W-1:0];
  endtask

  task automatic configure(input logic [SAMPLE_W-1:0] thr, input logic [STEPS_W-1:0] stp);
    write_register(CFG_THRESHOLD, thr);
    write_register(CFG_STEPS, stp);
    settings_used++;
  endtask

  // holds the sender until every expected word has come back
  task automatic drain_block();
    while (pending_distances.size() != 0 || expected_steps.size() != 0 || samples_if.valid)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // sample driver
  int tx_burst = 0;
  int tx_gap = 0;
  always @(negedge clk) begin
    if (rst) begin
      samples_if.valid <= 1'b0;
    end else if (samples_if.valid && !in_fire) begin
      samples_if.valid <= 1'b1;
    end else if (tx_gap > 0) begin
      samples_if.valid <= 1'b0;
      tx_gap--;
    end else if (pending_distances.size() == 0) begin
      samples_if.valid <= 1'b0;
    end else begin
      samples_if.valid <= 1'b1;
      samples_if.distance <= pending_distances[0];
      if (tx_burst == 0) tx_burst = $urandom_range(1, 8);
      tx_burst--;
      if (tx_burst == 0 && tx_gaps_on)
        tx_gap = ($urandom_range(0, 9) == 0) ? 40 : $urandom_range(1, 6);
    end
  end

  // result receiver stall pattern
  int   rx_run = 0;
  logic rx_high = 1'b0;
  always @(negedge clk) begin
    if (rst) begin
      results_if.ready <= 1'b0;
    end else if (!rx_stall_on) begin
      results_if.ready <= 1'b1;
    end else begin
      if (rx_run == 0) begin
        rx_high = !rx_high;
        if (rx_high) rx_run = $urandom_range(1, 12);
        else rx_run = ($urandom_range(0, 15) == 0) ? 30 : $urandom_range(1, 5);
      end
      rx_run--;
      results_if.ready <= rx_high;
    end
  end

  // monitor
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= samples_if.valid && samples_if.ready;
      if (samples_if.valid && samples_if.ready) begin
        predict_sample(samples_if.distance);
        void'(pending_distances.pop_front());
        samples_taken++;
      end
      if (results_if.valid && results_if.ready) begin
        got.coil_pattern = results_if.coil_pattern;
        got.last_step = results_if.last_step;
        got.scan_angle = results_if.scan_angle;
        got.changed = results_if.changed;
        got.reported_value = results_if.reported_value;
        if (expected_steps.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected word: coil=%h last=%b angle=%0d chg=%b val=%h",
                     got.coil_pattern, got.last_step, got.scan_angle, got.changed,
                     got.reported_value);
        end else begin
          want = expected_steps.pop_front();
          words_checked++;
          if (got.changed && got.last_step) changes_seen++;
          if (got.coil_pattern !== want.coil_pattern || got.last_step !== want.last_step ||
              got.scan_angle !== want.scan_angle || got.changed !== want.changed ||
              got.reported_value !== want.reported_value) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch word %0d: exp coil=%h last=%b angle=%0d chg=%b val=%h, %s",
                       words_checked, want.coil_pattern, want.last_step, want.scan_angle,
                       want.changed, want.reported_value, "see actual below");
            if (fail_count <= 10)
              $display("  act coil=%h last=%b angle=%0d chg=%b val=%h",
                       got.coil_pattern, got.last_step, got.scan_angle, got.changed,
                       got.reported_value);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int p;
    int n;
    int count;
    logic [SAMPLE_W-1:0] thr;
    logic [STEPS_W-1:0]  stp;
    cfg_we = 1'b0;
    cfg_index = CFG_THRESHOLD;
    cfg_data = '0;
    samples_if.valid = 1'b0;
    samples_if.distance = '0;
    results_if.ready = 1'b0;
    thresh_cfg = THRESHOLD_RESET;
    step_cfg = STEPS_RESET;
    sweep_pos = ANGLE_TOP;
    sweep_dn = 1'b1;
    coil_ph = PHASE_RESET;
    for (n = 0; n < ANGLE_COUNT; n++) stored_val[n] = '0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: below, at and far beyond the threshold
    pending_distances = '{SAMPLE_W'(0), DIST_MAX, SAMPLE_W'(49), SAMPLE_W'(50), DIST_MAX};
    drain_block();

    // zero threshold with step count zero
    configure('0, '0);
    pending_distances = '{SAMPLE_W'(0), SAMPLE_W'(0), DIST_MAX, SAMPLE_W'(7)};
    drain_block();

    // full-scale threshold with step count above the maximum
    configure(DIST_MAX, 6'd63);
    pending_distances = '{SAMPLE_W'(0), DIST_MAX, DIST_MAX - 1'b1};
    drain_block();

    // threshold one, step count just over the maximum, then exactly one
    configure(SAMPLE_W'(1), 6'd33);
    pending_distances = '{SAMPLE_W'(0), SAMPLE_W'(1)};
    drain_block();
    configure(SAMPLE_W'(1), 6'd1);
    pending_distances = '{SAMPLE_W'(1), SAMPLE_W'(2), SAMPLE_W'(0)};
    drain_block();

    for (p = 0; p < 6; p++) begin
      case (p)
        0: begin thr = SAMPLE_W'(50); stp = 6'd1; count = 70; end
        1: begin
          thr = SAMPLE_W'($urandom_range(0, 200));
          stp = STEPS_W'($urandom_range(2, 4));
          count = 25;
        end
        2: begin thr = SAMPLE_W'($urandom); stp = 6'd0; count = 25; end
        3: begin thr = '0; stp = STEPS_W'($urandom_range(1, 63)); count = 25; end
        4: begin thr = DIST_MAX; stp = 6'd2; count = 25; end
        default: begin thr = SAMPLE_W'($urandom_range(1, 100)); stp = 6'd32; count = 25; end
      endcase
      tx_gaps_on = (p != 2);
      rx_stall_on = (p != 2);
      configure(thr, stp);
      for (n = 0; n < count; n++) pending_distances.push_back(pick_distance());
      drain_block();
    end

    repeat (20) @(posedge clk);
    $display("covered %0d samples, %0d step words, %0d stored changes over %0d settings",
             samples_taken, words_checked, changes_seen, settings_used);
    if (fail_count == 0 && expected_steps.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end
endmodule

@@ sweep_scan_change_detector_unit.f @@
rtl/core/sscd_pkg.sv
rtl/core/sscd_if.sv
rtl/core/sscd_table.sv
rtl/core/sscd_sequencer.sv
rtl/core/sscd_sweep.sv
rtl/core/sweep_scan_change_detector_unit.sv
test/tb.sv
